// ===== hw/rtl/sst_pkg.sv =====
// ---------------------------------------------------------------------------
// sst_pkg
// shared types and constants of the session slot table
// ---------------------------------------------------------------------------
package sst_pkg;

   localparam int SLOTS   = 256;
   localparam int IDX_W   = $clog2(SLOTS);
   localparam int CNT_W   = $clog2(SLOTS + 1);
   localparam int PID_W   = 22;
   localparam int USER_W  = 24;
   localparam int STAT_W  = 8;
   localparam int ORDER_W = 9;
   localparam int MCNT_W  = 9;

   localparam logic [2:0] ACT_ALLOC  = 3'd0;
   localparam logic [2:0] ACT_FREE   = 3'd1;
   localparam logic [2:0] ACT_FIND   = 3'd2;
   localparam logic [2:0] ACT_COUNT  = 3'd3;
   localparam logic [2:0] ACT_NTH    = 3'd4;
   localparam logic [2:0] ACT_STATUS = 3'd5;

   localparam logic [MCNT_W-1:0] MCNT_MAX = '1;

   typedef struct packed {
      logic [PID_W-1:0]  pid;
      logic [USER_W-1:0] user;
      logic [STAT_W-1:0] status;
   } slot_type;

   // operation word held for the whole scan while the slot data circulates along the ring
   typedef struct packed {
      logic [2:0]         action;
      logic [PID_W-1:0]   pid;
      logic [USER_W-1:0]  user;
      logic [STAT_W-1:0]  bits;
      logic [IDX_W-1:0]   slot;
      logic [ORDER_W-1:0] order;
      logic [IDX_W-1:0]   top;
   } op_type;

   typedef struct packed {
      logic              ok;
      logic [IDX_W-1:0]  idx;
      logic [MCNT_W-1:0] cnt;
      logic              alloc_done;
      logic              free_done;
   } acc_type;

   typedef struct packed {
      logic              ok;
      logic [IDX_W-1:0]  slot_index;
      logic [MCNT_W-1:0] match_count;
      logic [CNT_W-1:0]  active_total;
      logic [IDX_W-1:0]  high_water;
   } rsp_type;

endpackage

// ===== hw/rtl/sst_if.sv =====
// ---------------------------------------------------------------------------
// sst_req_if / sst_rsp_if
// valid/ready channels of the session slot table
// ---------------------------------------------------------------------------
interface sst_req_if;
   import sst_pkg::*;
   logic               valid;
   logic               ready;
   logic [2:0]         action;
   logic [PID_W-1:0]   pid;
   logic [USER_W-1:0]  user_number;
   logic [STAT_W-1:0]  status_bits;
   logic [IDX_W-1:0]   slot;
   logic [ORDER_W-1:0] order;
   modport source (output valid, action, pid, user_number, status_bits, slot, order,
                   input ready);
   modport sink   (input valid, action, pid, user_number, status_bits, slot, order,
                   output ready);
endinterface

interface sst_rsp_if;
   import sst_pkg::*;
   logic              valid;
   logic              ready;
   logic              ok;
   logic [IDX_W-1:0]  slot_index;
   logic [MCNT_W-1:0] match_count;
   logic [CNT_W-1:0]  active_total;
   logic [IDX_W-1:0]  high_water;
   modport source (output valid, ok, slot_index, match_count, active_total, high_water,
                   input ready);
   modport sink   (input valid, ok, slot_index, match_count, active_total, high_water,
                   output ready);
endinterface

// ===== hw/rtl/session_slot_table.sv =====
// ---------------------------------------------------------------------------
// session_slot_table
// fixed table of session slots held in a rotating ring of cells
// ---------------------------------------------------------------------------
// Usage: a request word enters on the req_ channel (valid/ready) and one
// response word leaves on the rsp_ channel for each request.
// The slots form a ring of SLOTS cells. For every request the ring turns
// once in full, one slot per cycle, and the head logic updates or compares
// the slot that passes it; after a full turn every slot is back in place.
// An item therefore takes one full turn of scan and then a load of the
// response register. One item is worked on at a time; the next request
// is taken as soon as the response register is loaded, even while the
// response still waits.
// Reset (synchronous) clears every slot, the active count and the high
// water mark at once. A stalled receiver holds the response; a second
// finished item waits in the done state until the response register frees.
// ---------------------------------------------------------------------------
module session_slot_table
   import sst_pkg::*;
(
   input  logic clock,
   input  logic reset,
   sst_req_if.sink   req,
   sst_rsp_if.source rsp
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]         state_ff, state_in;
   op_type             op_ff, op_in;
   acc_type            acc_ff, acc_in;
   logic [ORDER_W-1:0] left_ff, left_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic [CNT_W-1:0]   active_ff, active_in;
   logic [IDX_W-1:0]   mark_ff, mark_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   slot_type ring [SLOTS];
   slot_type head_out;
   acc_type  head_acc;
   logic [ORDER_W-1:0] head_left;
   logic     shift;

   assign shift = (state_ff == ST_SCAN);

   // the ring: cell 0 feeds the head logic, whose output goes into the last cell
   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      slot_type nxt;
      if (g == SLOTS - 1) begin : g_wrap
         assign nxt = head_out;
      end else begin : g_link
         assign nxt = ring[g+1];
      end
      sst_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift    (shift),
         .slot_in  (nxt),
         .slot_out (ring[g])
      );
   end

   sst_head u_head (
      .op       (op_ff),
      .pos      (pos_ff),
      .slot_in  (ring[0]),
      .acc_in   (acc_ff),
      .left_in  (left_ff),
      .slot_out (head_out),
      .acc_out  (head_acc),
      .left_out (head_left)
   );

   assign req.ready = (state_ff == ST_IDLE);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      acc_in       = acc_ff;
      left_in      = left_ff;
      pos_in       = pos_ff;
      active_in    = active_ff;
      mark_in      = mark_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp.valid && rsp.ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               op_in.action = req.action;
               op_in.pid    = req.pid;
               op_in.user   = req.user_number;
               op_in.bits   = req.status_bits;
               op_in.slot   = req.slot;
               op_in.order  = (req.action == ACT_FIND) ? ORDER_W'(1) : req.order;
               op_in.top    = mark_ff;
               left_in      = (req.action == ACT_FIND) ? ORDER_W'(1) : req.order;
               acc_in       = '0;
               pos_in       = '0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            acc_in  = head_acc;
            left_in = head_left;
            pos_in  = pos_ff + IDX_W'(1);
            if (pos_ff == IDX_W'(SLOTS - 1)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_in) begin
               if (acc_ff.alloc_done) begin
                  if (active_ff != CNT_W'(SLOTS)) active_in = active_ff + CNT_W'(1);
                  if (acc_ff.idx > mark_ff) mark_in = acc_ff.idx;
               end
               if (acc_ff.free_done && active_ff != '0) active_in = active_ff - CNT_W'(1);
               rsp_in.ok           = acc_ff.ok;
               rsp_in.slot_index   = (op_ff.action == ACT_COUNT ||
                                      op_ff.action == ACT_STATUS || !acc_ff.ok)
                                     ? '0 : acc_ff.idx;
               rsp_in.match_count  = acc_ff.cnt;
               rsp_in.active_total = active_in;
               rsp_in.high_water   = mark_in;
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         mark_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         mark_ff      <= mark_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      acc_ff  <= acc_in;
      left_ff <= left_in;
      pos_ff  <= pos_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.ok           = rsp_ff.ok;
   assign rsp.slot_index   = rsp_ff.slot_index;
   assign rsp.match_count  = rsp_ff.match_count;
   assign rsp.active_total = rsp_ff.active_total;
   assign rsp.high_water   = rsp_ff.high_water;

endmodule

// ===== hw/rtl/sst_cell.sv =====
// ---------------------------------------------------------------------------
// sst_cell
// one slot of the table; the ring rotates by one slot a cycle during a scan
// ---------------------------------------------------------------------------
module sst_cell
   import sst_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     shift,
   input  slot_type slot_in,
   output slot_type slot_out
);

   slot_type slot_ff;

   // take the neighbour's slot when the ring turns
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else if (shift) begin
         slot_ff <= slot_in;
      end
   end

   assign slot_out = slot_ff;

endmodule

// ===== hw/rtl/sst_head.sv =====
// ---------------------------------------------------------------------------
// sst_head
// works on the slot that passes the head of the ring in each scan cycle
// ---------------------------------------------------------------------------
module sst_head
   import sst_pkg::*;
(
   input  op_type           op,
   input  logic [IDX_W-1:0] pos,
   input  slot_type         slot_in,
   input  acc_type          acc_in,
   input  logic [ORDER_W-1:0] left_in,
   output slot_type         slot_out,
   output acc_type          acc_out,
   output logic [ORDER_W-1:0] left_out
);

   logic hit;
   logic in_range;

   assign in_range = (pos <= op.top);
   assign hit      = in_range && (slot_in.user == op.user);

   // per-slot update of the passing slot and of the running result
   always_comb begin
      slot_out = slot_in;
      acc_out  = acc_in;
      left_out = left_in;
      case (op.action)
         ACT_ALLOC: begin
            if (!acc_in.alloc_done && op.pid != '0 && slot_in.pid == '0) begin
               slot_out.pid    = op.pid;
               slot_out.user   = op.user;
               slot_out.status = op.bits;
               acc_out.ok         = 1'b1;
               acc_out.idx        = pos;
               acc_out.alloc_done = 1'b1;
            end
         end
         ACT_FREE: begin
            if (pos == op.slot && slot_in.pid != '0) begin
               slot_out.pid  = '0;
               slot_out.user = '0;
               acc_out.ok        = 1'b1;
               acc_out.idx       = pos;
               acc_out.free_done = 1'b1;
            end
         end
         ACT_FIND, ACT_NTH: begin
            if (hit && !acc_in.ok) begin
               if (left_in <= ORDER_W'(1)) begin
                  acc_out.ok  = 1'b1;
                  acc_out.idx = pos;
               end else begin
                  left_out = left_in - ORDER_W'(1);
               end
            end
         end
         ACT_COUNT: begin
            if (hit) begin
               acc_out.ok = 1'b1;
               if (acc_in.cnt != MCNT_MAX) acc_out.cnt = acc_in.cnt + MCNT_W'(1);
            end
         end
         ACT_STATUS: begin
            if (hit) begin
               slot_out.status = slot_in.status | op.bits;
               acc_out.ok      = 1'b1;
            end
         end
         default: ;
      endcase
   end

endmodule

// ===== hw/rtl/sst_checker.sv =====
// ---------------------------------------------------------------------------
// sst_checker
// port-level checks of the session slot table
// ---------------------------------------------------------------------------
module sst_checker
   import sst_pkg::*;
(
   input logic clock,
   input logic reset,
   sst_req_if.sink   req,
   sst_rsp_if.source rsp
);

   // a stalled response word stays valid and keeps its high water mark
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.high_water))
      else $error("response changed while stalled");

   // no response can come in the cycle after a request is taken
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !$rose(rsp.valid))
      else $error("response too early");

   // the high water mark never falls between successive response words
   a_mark: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |=> !rsp.valid || rsp.high_water >= $past(rsp.high_water, 1))
      else $error("high water mark fell");

   // a failed answer carries slot index zero
   a_idx: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ok |-> rsp.slot_index == '0)
      else $error("slot index set without ok");

   // the active total stays within the table
   a_total: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.active_total <= CNT_W'(SLOTS))
      else $error("active total out of range");

endmodule

bind session_slot_table sst_checker u_sst_checker (
   .clock (clock),
   .reset (reset),
   .req   (req),
   .rsp   (rsp)
);
